@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/atan2_pkg.sv @@
// ----------------------------------------------------------------------------
// atan2_pkg
// Shared constants and per-stage control types for the atan2 pipeline.
// ----------------------------------------------------------------------------
package atan2_pkg;

  localparam int ANGLE_BITS = 15;
  localparam int FRAC_BITS  = 12;
  localparam logic signed [ANGLE_BITS-1:0] PI_Q12      = 15'sd12868;
  localparam logic signed [ANGLE_BITS-1:0] HALF_PI_Q12 = 15'sd6434;

  // Sideband that travels with each word through the pipeline.
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
    logic b_lt_a;
  } atan2_ctl_t;

endpackage

@@ rtl/atan2_div_step.sv @@
// ----------------------------------------------------------------------------
// atan2_div_step
// One registered group of restoring-division steps for the fraction
// quotient; carries its word's valid bit and sideband along.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atan2_div_step #(
  parameter int W     = 40,
  parameter int STEPS = 3,
  parameter int QB    = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  atan2_pkg::atan2_ctl_t  in_ctl,
  input  logic [W-1:0]           in_rem,
  input  logic [W-1:0]           in_den,
  input  logic [QB-1:0]          in_q,
  output logic                   out_valid,
  output atan2_pkg::atan2_ctl_t  out_ctl,
  output logic [W-1:0]           out_rem,
  output logic [W-1:0]           out_den,
  output logic [QB-1:0]          out_q
);

  logic [W-1:0]  rem_next;
  logic [QB-1:0] q_next;

  // Shift-compare-subtract; the remainder stays below den so W+1 bits suffice.
  always_comb begin
    logic [W:0] t;
    rem_next = in_rem;
    q_next   = in_q;
    for (int i = 0; i < STEPS; i++) begin
      t = {rem_next, 1'b0};
      q_next = {q_next[QB-2:0], 1'b0};
      if (t >= {1'b0, in_den}) begin
        t = t - {1'b0, in_den};
        q_next[0] = 1'b1;
      end
      rem_next = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl <= in_ctl;
      out_rem <= rem_next;
      out_den <= in_den;
      out_q   <= q_next;
    end
  end

  // Remainder must stay below the divisor for each live word.
  `ASSERT_IMP(a_rem_lt_den, clk, rst, out_valid && (out_den != '0), out_rem < out_den, "rem >= den")
  // A held stage keeps its valid bit.
  `ASSERT_NEXT(a_valid_hold, clk, rst, !en, $stable(out_valid), "valid changed in stall")
  // A held live word keeps its partial quotient.
  `ASSERT_NEXT(a_q_hold, clk, rst, out_valid && !en, $stable(out_q) && out_valid, "q changed")

endmodule

@@ rtl/atan2_rational_approx_unit.sv @@
// ----------------------------------------------------------------------------
// atan2_rational_approx_unit
// Four-quadrant angle of (y, x) in Q3.12 radians, 0.28 rational approximation.
// ----------------------------------------------------------------------------
// One word enters per cycle while the output is not stalled, and its angle
// reaches the output through eight register stages: one for magnitudes, one
// for the products, one for the scaled numerator and denominator, four
// stages of three division steps each for the 12-bit quotient, and one for
// the quadrant fixup into the output register. A stall at the output holds
// the whole pipeline in place.
`include "assert_macros.svh"

module atan2_rational_approx_unit #(
  parameter int IN_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [IN_BITS-1:0]            y_value,
  input  logic signed [IN_BITS-1:0]            x_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [atan2_pkg::ANGLE_BITS-1:0] angle
);

  localparam int MB = IN_BITS;           // magnitude bits (holds 2^(IN_BITS-1))
  localparam int PB = 2 * MB;            // product bits
  localparam int W  = PB + 6;            // 32*max product fits
  localparam int QB = atan2_pkg::FRAC_BITS;
  localparam int NDIV = 4;
  localparam int SPS  = QB / NDIV;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: magnitudes and signs.
  logic                  s1_v;
  atan2_pkg::atan2_ctl_t s1_ctl;
  logic [MB-1:0]         s1_a, s1_b;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_a <= x_value[IN_BITS-1] ? MB'(-{x_value[IN_BITS-1], x_value}) : MB'(x_value);
      s1_b <= y_value[IN_BITS-1] ? MB'(-{y_value[IN_BITS-1], y_value}) : MB'(y_value);
      s1_ctl.x_zero <= (x_value == '0);
      s1_ctl.y_zero <= (y_value == '0);
      s1_ctl.x_neg  <= x_value[IN_BITS-1];
      s1_ctl.y_neg  <= y_value[IN_BITS-1];
      s1_ctl.b_lt_a <= 1'b0;
    end
  end

  // Stage 2: products.
  logic                  s2_v;
  atan2_pkg::atan2_ctl_t s2_ctl;
  logic [PB-1:0]         s2_ab, s2_aa, s2_bb;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_ab  <= s1_a * s1_b;
      s2_aa  <= s1_a * s1_a;
      s2_bb  <= s1_b * s1_b;
      s2_ctl <= atan2_pkg::atan2_ctl_t'{x_zero: s1_ctl.x_zero, y_zero: s1_ctl.y_zero,
                                        x_neg: s1_ctl.x_neg, y_neg: s1_ctl.y_neg,
                                        b_lt_a: (s1_b < s1_a)};
    end
  end

  // Stage 3: scaled numerator and denominator (x25 = 16+8+1, x7 = 8-1).
  logic                  s3_v;
  atan2_pkg::atan2_ctl_t s3_ctl;
  logic [W-1:0]          s3_num, s3_den;
  logic [W-1:0]          big, lit;
  always_comb begin
    big = s2_ctl.b_lt_a ? W'(s2_aa) : W'(s2_bb);
    lit = s2_ctl.b_lt_a ? W'(s2_bb) : W'(s2_aa);
  end
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_num <= (W'(s2_ab) << 4) + (W'(s2_ab) << 3) + W'(s2_ab);
      s3_den <= (big << 4) + (big << 3) + big + (lit << 3) - lit;
      s3_ctl <= s2_ctl;
    end
  end

  // Stages 4..7: quotient, SPS bits per stage.
  logic                  d_v   [NDIV+1];
  atan2_pkg::atan2_ctl_t d_ctl [NDIV+1];
  logic [W-1:0]          d_rem [NDIV+1];
  logic [W-1:0]          d_den [NDIV+1];
  logic [QB-1:0]         d_q   [NDIV+1];
  assign d_v[0]   = s3_v;
  assign d_ctl[0] = s3_ctl;
  assign d_rem[0] = s3_num;
  assign d_den[0] = s3_den;
  assign d_q[0]   = '0;

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    atan2_div_step #(.W(W), .STEPS(SPS), .QB(QB)) u_step (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(d_v[g]), .in_ctl(d_ctl[g]), .in_rem(d_rem[g]),
      .in_den(d_den[g]), .in_q(d_q[g]),
      .out_valid(d_v[g+1]), .out_ctl(d_ctl[g+1]), .out_rem(d_rem[g+1]),
      .out_den(d_den[g+1]), .out_q(d_q[g+1])
    );
  end

  // Final stage: sign and quadrant fixup.
  atan2_pkg::atan2_ctl_t fc;
  logic signed [atan2_pkg::ANGLE_BITS-1:0] sq, ang_next;
  always_comb begin
    fc = d_ctl[NDIV];
    sq = (fc.x_neg != fc.y_neg) ? -$signed({3'b000, d_q[NDIV]})
                                :  $signed({3'b000, d_q[NDIV]});
    if (fc.x_zero) begin
      if (fc.y_zero)     ang_next = '0;
      else if (fc.y_neg) ang_next = -atan2_pkg::HALF_PI_Q12;
      else               ang_next = atan2_pkg::HALF_PI_Q12;
    end else if (fc.b_lt_a) begin
      ang_next = sq;
      if (fc.x_neg)
        ang_next = fc.y_neg ? sq - atan2_pkg::PI_Q12 : sq + atan2_pkg::PI_Q12;
    end else begin
      ang_next = atan2_pkg::HALF_PI_Q12 - sq;
      if (fc.y_neg) ang_next = ang_next - atan2_pkg::PI_Q12;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= d_v[NDIV];
  end
  always_ff @(posedge clk) begin
    if (en) angle <= ang_next;
  end

  // A stalled output word holds its angle.
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, $stable(angle) && out_valid, "stall lost word")
  // Output angle stays within +/- pi.
  `ASSERT_IMP(a_range, clk, rst, out_valid, (angle <= atan2_pkg::PI_Q12) && (angle >= -atan2_pkg::PI_Q12), "angle out of range")
  // Ready follows the output stall exactly.
  `ASSERT_IMP(a_ready, clk, rst, 1'b1, in_ready == (!out_valid || out_ready), "ready mismatch")

endmodule
